>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, skipped while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/igdt_pkg.sv
package igdt_pkg;

   localparam int ValueWidth  = 32;
   localparam int DigitWidth  = 4;
   localparam int NumDigits   = 10;
   localparam int BcdWidth    = NumDigits * DigitWidth;
   localparam int CharWidth   = 7;
   localparam int MarkWidth   = 3;
   localparam int CountWidth  = $clog2(NumDigits + 1);
   localparam int ShiftWidth  = $clog2(ValueWidth);

   localparam logic [CharWidth-1:0] CharComma      = 7'h2C;
   localparam logic [CharWidth-1:0] CharSpace      = 7'h20;
   localparam logic [CharWidth-1:0] CharApostrophe = 7'h27;
   localparam logic [CharWidth-1:0] CharUnderscore = 7'h5F;
   localparam logic [CharWidth-1:0] CharTilde      = 7'h7E;
   localparam logic [CharWidth-1:0] CharQuote      = 7'h22;
   localparam logic [CharWidth-1:0] CharSlash      = 7'h2F;
   localparam logic [CharWidth-1:0] CharMinus      = 7'h2D;
   localparam logic [CharWidth-DigitWidth-1:0] CharDigitBase = 3'b011;

   localparam logic [MarkWidth-1:0] MarkReset      = 3'd1;
   localparam logic [MarkWidth-1:0] MarkSpace      = 3'd2;
   localparam logic [MarkWidth-1:0] MarkApostrophe = 3'd3;
   localparam logic [MarkWidth-1:0] MarkUnderscore = 3'd4;
   localparam logic [MarkWidth-1:0] MarkTilde      = 3'd5;
   localparam logic [MarkWidth-1:0] MarkQuote      = 3'd6;
   localparam logic [MarkWidth-1:0] MarkSlash      = 3'd7;

   typedef struct packed {
      logic                done;
      logic [BcdWidth-1:0] digits;
   } bcd_result_type;

   function automatic logic [CharWidth-1:0] mark_char(input logic [MarkWidth-1:0] sel);
      logic [CharWidth-1:0] c;
      case (sel)
         MarkSpace:      c = CharSpace;
         MarkApostrophe: c = CharApostrophe;
         MarkUnderscore: c = CharUnderscore;
         MarkTilde:      c = CharTilde;
         MarkQuote:      c = CharQuote;
         MarkSlash:      c = CharSlash;
         default:        c = CharComma;
      endcase
      return c;
   endfunction

endpackage

>>> src/igdt_if.sv
interface igdt_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [igdt_pkg::ValueWidth-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface igdt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [igdt_pkg::CharWidth-1:0] char_code;
   logic                          last_char;
   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface igdt_csr_if;
   logic                          valid;
   logic                          ready;
   logic [igdt_pkg::MarkWidth-1:0] mark_select;
   modport source (output valid, output mark_select, input ready);
   modport sink (input valid, input mark_select, output ready);
endinterface

>>> src/igdt_bcd.sv
module igdt_bcd (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [igdt_pkg::ValueWidth-1:0]      mag,
   output igdt_pkg::bcd_result_type             result
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [igdt_pkg::ShiftWidth-1:0]      cnt_ff, cnt_in;
   logic [igdt_pkg::ValueWidth-1:0]      mag_ff, mag_in;
   logic [igdt_pkg::BcdWidth-1:0]        bcd_ff, bcd_in;
   logic [igdt_pkg::BcdWidth-1:0]        adj;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < igdt_pkg::NumDigits; d++) begin
         if (bcd_ff[d*igdt_pkg::DigitWidth +: igdt_pkg::DigitWidth] >= 4'd5) begin
            adj[d*igdt_pkg::DigitWidth +: igdt_pkg::DigitWidth] =
               bcd_ff[d*igdt_pkg::DigitWidth +: igdt_pkg::DigitWidth] + 4'd3;
         end else begin
            adj[d*igdt_pkg::DigitWidth +: igdt_pkg::DigitWidth] =
               bcd_ff[d*igdt_pkg::DigitWidth +: igdt_pkg::DigitWidth];
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mag_in  = mag;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bcd_in = {adj[igdt_pkg::BcdWidth-2:0], mag_ff[igdt_pkg::ValueWidth-1]};
         mag_in = {mag_ff[igdt_pkg::ValueWidth-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (&cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign result.done   = done_ff;
   assign result.digits = bcd_ff;

endmodule

>>> src/integer_to_grouped_decimal_text_unit.sv
// Renders one signed 32-bit value as grouped decimal ASCII text, one character per
// rsp transaction, most significant first, with last_char set on the final one. The
// magnitude is converted to BCD one bit per cycle, leading zero digits are then
// dropped one per cycle (up to 9), and characters leave at one per cycle while rsp
// is ready. A new value is accepted once the last character of the previous one
// sits in the output register. csr writes are always ready and should only be made
// while the unit is idle.
`include "assert_macros.svh"

module integer_to_grouped_decimal_text_unit (
   input logic          clock,
   input logic          reset,
   igdt_req_if.sink     req_bus,
   igdt_rsp_if.source   rsp_bus,
   igdt_csr_if.sink     csr_bus
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_EMIT
   } state_type;

   localparam logic [igdt_pkg::CountWidth-1:0] RemOne = igdt_pkg::CountWidth'(1);

   state_type                           state_ff, state_in;
   logic [igdt_pkg::MarkWidth-1:0]      mark_ff, mark_in;
   logic                                neg_ff, neg_in;
   logic                                neg_pend_ff, neg_pend_in;
   logic                                mark_pend_ff, mark_pend_in;
   logic [igdt_pkg::BcdWidth-1:0]       digits_ff, digits_in;
   logic [igdt_pkg::CountWidth-1:0]     rem_ff, rem_in;
   logic [1:0]                          grp_ff, grp_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [igdt_pkg::CharWidth-1:0]      char_ff, char_in;
   logic                                last_ff, last_in;

   logic                                req_accept;
   logic                                slot_free;
   logic [igdt_pkg::ValueWidth-1:0]     raw;
   logic [igdt_pkg::ValueWidth-1:0]     mag;
   logic [igdt_pkg::DigitWidth-1:0]     top_digit;
   logic [1:0]                          grp_dec;
   igdt_pkg::bcd_result_type            bcd_res;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign raw           = req_bus.value;
   assign mag           = raw[igdt_pkg::ValueWidth-1] ? (~raw + 32'd1) : raw;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign top_digit     = digits_ff[igdt_pkg::BcdWidth-1 -: igdt_pkg::DigitWidth];
   assign grp_dec       = (grp_ff == 2'd0) ? 2'd2 : grp_ff - 2'd1;

   igdt_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .mag    (mag),
      .result (bcd_res)
   );

   always_comb begin
      state_in     = state_ff;
      mark_in      = mark_ff;
      neg_in       = neg_ff;
      neg_pend_in  = neg_pend_ff;
      mark_pend_in = mark_pend_ff;
      digits_in    = digits_ff;
      rem_in       = rem_ff;
      grp_in       = grp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      char_in      = char_ff;
      last_in      = last_ff;

      if (csr_bus.valid) begin
         mark_in = csr_bus.mark_select;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               neg_in   = raw[igdt_pkg::ValueWidth-1];
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (bcd_res.done) begin
               digits_in = bcd_res.digits;
               rem_in    = igdt_pkg::CountWidth'(igdt_pkg::NumDigits);
               grp_in    = 2'd0;
               state_in  = ST_TRIM;
            end
         end
         ST_TRIM: begin
            // drop one leading zero digit per cycle, keep at least one
            if (top_digit == '0 && rem_ff > RemOne) begin
               digits_in = digits_ff << igdt_pkg::DigitWidth;
               rem_in    = rem_ff - RemOne;
               grp_in    = grp_dec;
            end else begin
               neg_pend_in  = neg_ff;
               mark_pend_in = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (neg_pend_ff) begin
                  char_in     = igdt_pkg::CharMinus;
                  last_in     = 1'b0;
                  neg_pend_in = 1'b0;
               end else if (mark_pend_ff) begin
                  char_in      = igdt_pkg::mark_char(mark_ff);
                  last_in      = 1'b0;
                  mark_pend_in = 1'b0;
               end else begin
                  char_in      = {igdt_pkg::CharDigitBase, top_digit};
                  last_in      = (rem_ff == RemOne);
                  mark_pend_in = (rem_ff > RemOne) && (grp_ff == 2'd0);
                  digits_in    = digits_ff << igdt_pkg::DigitWidth;
                  rem_in       = rem_ff - RemOne;
                  grp_in       = grp_dec;
                  if (rem_ff == RemOne) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mark_ff      <= igdt_pkg::MarkReset;
         rsp_valid_ff <= 1'b0;
         neg_pend_ff  <= 1'b0;
         mark_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
         neg_pend_ff  <= neg_pend_in;
         mark_pend_ff <= mark_pend_in;
      end
      neg_ff    <= neg_in;
      digits_ff <= digits_in;
      rem_ff    <= rem_in;
      grp_ff    <= grp_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.char_code = char_ff;
   assign rsp_bus.last_char = last_ff;

   `ASSERT_IMPL(a_done_in_convert, clock, reset, bcd_res.done, state_ff == ST_CONVERT)
   `ASSERT_IMPL(a_emit_has_digits, clock, reset, state_ff == ST_EMIT, rem_ff != '0)
   `ASSERT_IMPL(a_mark_after_minus, clock, reset, mark_pend_ff, !neg_pend_ff)
   `ASSERT_NEXT(a_accept_starts, clock, reset, req_accept, state_ff == ST_CONVERT)

endmodule

>>> tb/grouped_text_checker.sv
`timescale 1ns / 1ps

module grouped_text_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic signed [igdt_pkg::ValueWidth-1:0] req_value,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [igdt_pkg::CharWidth-1:0]         rsp_char_code,
   input  logic                                   rsp_last_char,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [igdt_pkg::MarkWidth-1:0]         csr_mark_select,
   output int                                     fail_count,
   output int                                     chars_pending
);

   typedef struct packed {
      logic [igdt_pkg::CharWidth-1:0] char_code;
      logic                           last_char;
   } text_char_type;

   text_char_type                  expected_text[$];
   logic [igdt_pkg::MarkWidth-1:0] mark_sel = igdt_pkg::MarkReset;
   int                             mismatches = 0;

   // Leftover expectations count as failures at the end of the run.
   assign fail_count = mismatches + chars_pending;

   function automatic logic [igdt_pkg::CharWidth-1:0] grouping_mark(
      input logic [igdt_pkg::MarkWidth-1:0] sel);
      logic [igdt_pkg::CharWidth-1:0] mark;
      case (sel)
         igdt_pkg::MarkReset:      mark = igdt_pkg::CharComma;
         igdt_pkg::MarkSpace:      mark = igdt_pkg::CharSpace;
         igdt_pkg::MarkApostrophe: mark = igdt_pkg::CharApostrophe;
         igdt_pkg::MarkUnderscore: mark = igdt_pkg::CharUnderscore;
         igdt_pkg::MarkTilde:      mark = igdt_pkg::CharTilde;
         igdt_pkg::MarkQuote:      mark = igdt_pkg::CharQuote;
         igdt_pkg::MarkSlash:      mark = igdt_pkg::CharSlash;
         default:                  mark = igdt_pkg::CharComma;
      endcase
      return mark;
   endfunction

   function automatic void append_grouped_text(input logic [igdt_pkg::ValueWidth-1:0] raw,
                                               input logic [igdt_pkg::MarkWidth-1:0]  sel);
      logic [igdt_pkg::ValueWidth-1:0] mag;
      logic [igdt_pkg::DigitWidth-1:0] digit [igdt_pkg::NumDigits];
      logic                            neg;
      int                              n_digits;
      int                              total;
      int                              pos;
      neg = raw[igdt_pkg::ValueWidth-1];
      // Two's complement negation keeps the most negative value as 2147483648.
      mag = neg ? (~raw + 32'd1) : raw;
      n_digits = 0;
      do begin
         digit[n_digits] = igdt_pkg::DigitWidth'(mag % 32'd10);
         mag = mag / 32'd10;
         n_digits++;
      end while (mag != 0);
      total = (neg ? 1 : 0) + n_digits + (n_digits - 1) / 3;
      pos = 0;
      if (neg) begin
         expected_text.push_back({igdt_pkg::CharMinus, pos == total - 1});
         pos++;
      end
      for (int i = n_digits - 1; i >= 0; i--) begin
         expected_text.push_back({{igdt_pkg::CharDigitBase, digit[i]}, pos == total - 1});
         pos++;
         if (i > 0 && (i % 3) == 0) begin
            expected_text.push_back({grouping_mark(sel), pos == total - 1});
            pos++;
         end
      end
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         mark_sel = igdt_pkg::MarkReset;
      end else begin
         if (csr_valid && csr_ready) begin
            mark_sel = csr_mark_select;
         end
         if (req_valid && req_ready) begin
            append_grouped_text(req_value, mark_sel);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               $error("unexpected character transaction: char_code %h last_char %b",
                      rsp_char_code, rsp_last_char);
               mismatches++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_char_code !== want.char_code) begin
                  $error("char_code: expected %h, actual %h", want.char_code, rsp_char_code);
                  mismatches++;
               end
               if (rsp_last_char !== want.last_char) begin
                  $error("last_char: expected %b, actual %b", want.last_char, rsp_last_char);
                  mismatches++;
               end
            end
         end
      end
      chars_pending <= expected_text.size();
   end

endmodule

>>> tb/tb_integer_to_grouped_decimal_text_unit.sv
`timescale 1ns / 1ps

module tb_integer_to_grouped_decimal_text_unit;

   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 60;
   localparam int HoldOffAt     = 300;
   localparam int HoldOffCycles = 400;
   localparam int NumCorners    = 24;
   localparam int NumPhases     = 8;
   localparam int PhaseItems    = 55;
   // Code outside the listed marks, falls back to comma.
   localparam logic [igdt_pkg::MarkWidth-1:0] MarkZeroComma = 3'd0;

   logic clock;
   logic reset;
   int   fail_count;
   int   chars_pending;
   int   idle_cycles = 0;
   int   items_sent = 0;

   igdt_req_if req_bus ();
   igdt_rsp_if rsp_bus ();
   igdt_csr_if csr_bus ();

   integer_to_grouped_decimal_text_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   grouped_text_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_value       (req_bus.value),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_char_code   (rsp_bus.char_code),
      .rsp_last_char   (rsp_bus.last_char),
      .csr_valid       (csr_bus.valid),
      .csr_ready       (csr_bus.ready),
      .csr_mark_select (csr_bus.mark_select),
      .fail_count      (fail_count),
      .chars_pending   (chars_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [igdt_pkg::ValueWidth-1:0] draw_value();
      logic [igdt_pkg::ValueWidth-1:0] mag;
      int                              kind;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         mag = $urandom();
      end else if (kind == 2) begin
         case ($urandom_range(0, 5))
            0:       mag = 32'h8000_0000;
            1:       mag = 32'h7FFF_FFFF;
            2:       mag = 32'd0;
            3:       mag = 32'd999;
            4:       mag = 32'd1000;
            default: mag = 32'hFFFF_FFFF;
         endcase
      end else begin
         // Spread digit counts evenly: shift off a random number of bits, random sign.
         mag = $urandom() >> $urandom_range(0, 31);
         if ($urandom_range(0, 1) == 1) begin
            mag = ~mag + 32'd1;
         end
      end
      return mag;
   endfunction

   task automatic send_value(input logic [igdt_pkg::ValueWidth-1:0] value);
      int gap;
      gap = ((items_sent / 40) % 4 == 3) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
   endtask

   task automatic write_mark(input logic [igdt_pkg::MarkWidth-1:0] sel);
      csr_bus.valid       <= 1'b1;
      csr_bus.mark_select <= sel;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Response side: random stalls, stall-free stretches and one long hold-off.
   initial begin
      int stall;
      int received;
      received = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (received == HoldOffAt) begin
            stall = HoldOffCycles;
         end else if ((received / 120) % 3 == 2) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 13);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         received++;
      end
   end

   initial begin
      logic [igdt_pkg::ValueWidth-1:0] corner_values [NumCorners];
      logic [igdt_pkg::MarkWidth-1:0]  mark_order [NumPhases];
      corner_values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd99, 32'd100, 32'd999,
                        32'd1000, -32'sd1000, 32'd9999, 32'd12345, -32'sd123456,
                        32'd999999, 32'd1000000, -32'sd1234567, 32'd99999999,
                        32'd1000000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                        32'hAAAA_AAAA, -32'sd999, -32'sd1000000000};
      mark_order = '{MarkZeroComma, igdt_pkg::MarkSlash, igdt_pkg::MarkApostrophe,
                     igdt_pkg::MarkTilde, igdt_pkg::MarkReset, igdt_pkg::MarkQuote,
                     igdt_pkg::MarkSpace, igdt_pkg::MarkUnderscore};
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.value       <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.mark_select <= igdt_pkg::MarkReset;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corner values under the reset mark.
      for (int i = 0; i < NumCorners; i++) begin
         send_value(corner_values[i]);
      end

      for (int p = 0; p < NumPhases; p++) begin
         wait_until_drained();
         write_mark(mark_order[p]);
         // Hit the widest text right after each mark change.
         send_value(32'h8000_0000);
         for (int i = 1; i < PhaseItems; i++) begin
            send_value(draw_value());
         end
      end

      wait_until_drained();
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
